FILE: rtl/rrb_pkg.sv
// rrb_pkg: shared types and constants for the response reorder buffer
// holds op and status codes, field widths and the cell control struct
// no dependencies
package rrb_pkg;

   // default sizing handed to the top level parameters
   localparam int DEPTH_DEF     = 16;
   localparam int TAG_BITS_DEF  = 16;

   // fixed field widths of the channel words
   localparam int TAG_PORT_BITS = 16;
   localparam int WORD_BITS     = 64;
   localparam int OCC_BITS      = 5;

   // request operation codes
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_REPLY = 2'd1,
      OP_SEND  = 2'd2
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_DROPPED   = 2'd2
   } status_type;

   // per-cycle commands broadcast to every cell
   typedef struct packed {
      logic push;
      logic mark;
      logic send;
   } cell_ctrl_type;

endpackage

FILE: rtl/rrb_if.sv
// rrb_req_if and rrb_rsp_if: valid/ready channels of the response reorder buffer
// depends on rrb_pkg for codes and widths

// request channel: push, reply or send word
interface rrb_req_if;
   logic                           valid;
   logic                           ready;
   rrb_pkg::op_type                op;
   logic [rrb_pkg::TAG_PORT_BITS-1:0] req_tag;
   logic [rrb_pkg::WORD_BITS-1:0]  req_word;
   logic                           downstream_free;

   modport source (output valid, op, req_tag, req_word, downstream_free, input ready);
   modport sink   (input valid, op, req_tag, req_word, downstream_free, output ready);
endinterface

// response channel: one word per accepted request
interface rrb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           sent_valid;
   logic [rrb_pkg::TAG_PORT_BITS-1:0] sent_tag;
   logic [rrb_pkg::WORD_BITS-1:0]  sent_word;
   rrb_pkg::status_type            status;
   logic [rrb_pkg::OCC_BITS-1:0]   occupancy;
   logic                           nearly_full;
   logic                           can_start;

   modport source (output valid, sent_valid, sent_tag, sent_word, status, occupancy,
                   nearly_full, can_start, input ready);
   modport sink   (input valid, sent_valid, sent_tag, sent_word, status, occupancy,
                   nearly_full, can_start, output ready);
endinterface

FILE: rtl/rrb_cell.sv
// rrb_cell: one slot of the arrival-ordered buffer
// holds tag, word, serviced mark and valid; shifts from its right neighbor on removal
// depends on rrb_pkg for the control struct
module rrb_cell #(
   parameter int TAG_BITS  = rrb_pkg::TAG_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rrb_pkg::cell_ctrl_type        ctrl,
   input  logic [TAG_BITS-1:0]           cmp_tag,
   input  logic [rrb_pkg::WORD_BITS-1:0] new_word,
   // left neighbor state and priority chains
   input  logic                          left_valid,
   input  logic                          hit_in,
   output logic                          hit_out,
   input  logic                          done_in,
   output logic                          done_out,
   input  logic [TAG_BITS-1:0]           sel_tag_in,
   output logic [TAG_BITS-1:0]           sel_tag_out,
   input  logic [rrb_pkg::WORD_BITS-1:0] sel_word_in,
   output logic [rrb_pkg::WORD_BITS-1:0] sel_word_out,
   // right neighbor contents for the shift
   input  logic                          next_valid,
   input  logic                          next_done,
   input  logic [TAG_BITS-1:0]           next_tag,
   input  logic [rrb_pkg::WORD_BITS-1:0] next_word,
   // own contents toward the left neighbor
   output logic                          valid,
   output logic                          done,
   output logic [TAG_BITS-1:0]           tag,
   output logic [rrb_pkg::WORD_BITS-1:0] word
);

   logic                          valid_ff, valid_in;
   logic                          done_ff, done_in_nxt;
   logic [TAG_BITS-1:0]           tag_ff, tag_in;
   logic [rrb_pkg::WORD_BITS-1:0] word_ff, word_in;

   logic match;
   logic first_hit;
   logic serviced;
   logic first_done;
   logic take;
   logic load;

   // oldest-first tag match chain
   assign match     = valid_ff & (tag_ff == cmp_tag);
   assign first_hit = match & ~hit_in;
   assign hit_out   = hit_in | match;

   // oldest serviced entry chain; this cell and all younger ones shift on send
   assign serviced   = valid_ff & done_ff;
   assign first_done = serviced & ~done_in;
   assign done_out   = done_in | serviced;
   assign take       = ctrl.send & done_out;

   // the emitted entry travels down the chain
   assign sel_tag_out  = first_done ? tag_ff  : sel_tag_in;
   assign sel_word_out = first_done ? word_ff : sel_word_in;

   // push lands in the first empty slot
   assign load = ctrl.push & ~valid_ff & left_valid;

   // next state
   always_comb begin
      valid_in    = valid_ff;
      done_in_nxt = done_ff;
      tag_in      = tag_ff;
      word_in     = word_ff;
      if (load) begin
         valid_in    = 1'b1;
         done_in_nxt = 1'b0;
         tag_in      = cmp_tag;
         word_in     = new_word;
      end else if (ctrl.mark && first_hit) begin
         done_in_nxt = 1'b1;
      end else if (take) begin
         valid_in    = next_valid;
         done_in_nxt = next_done;
         tag_in      = next_tag;
         word_in     = next_word;
      end
   end

   // control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in_nxt;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      word_ff <= word_in;
   end

   assign valid = valid_ff;
   assign done  = done_ff;
   assign tag   = tag_ff;
   assign word  = word_ff;

endmodule

FILE: rtl/response_reorder_buffer_core.sv
// response_reorder_buffer_core: top level of the response reorder buffer
// a row of rrb_cell slots in arrival order with a two-step sequencer
// depends on rrb_pkg, rrb_req_if, rrb_rsp_if and rrb_cell
//
//   channel   direction  words carried
//   req_bus   in         op, req_tag, req_word, downstream_free
//   rsp_bus   out        sent_valid, sent_tag, sent_word, status, occupancy, flags
//
// a request is accepted in S_IDLE and pushes or marks in the cells; S_SEND then
// removes the oldest serviced entry (reply or send with downstream_free set)
// and loads the response register, waiting while it holds a word not yet taken
// a request may be accepted while the previous response is still waiting
// synchronous active-high reset empties all cells; no clearing pass is needed
module response_reorder_buffer_core #(
   parameter int DEPTH    = rrb_pkg::DEPTH_DEF,
   parameter int TAG_BITS = rrb_pkg::TAG_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rrb_req_if.sink   req_bus,
   rrb_rsp_if.source rsp_bus
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int TP       = rrb_pkg::TAG_PORT_BITS;
   localparam int WB       = rrb_pkg::WORD_BITS;
   localparam int OB       = rrb_pkg::OCC_BITS;
   localparam logic [CNT_BITS-1:0]   FULL_CNT  = CNT_BITS'(DEPTH);
   localparam logic [CNT_BITS-1:0]   NEAR_LIM  = CNT_BITS'(DEPTH - 3);
   localparam logic [CNT_BITS+1:0]   START_LIM = (CNT_BITS + 2)'(3 * DEPTH);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SEND = 2'b10
   } fsm_type;

   fsm_type                 state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   rrb_pkg::op_type         op_ff, op_in;
   logic                    free_ff, free_in;
   rrb_pkg::status_type     stat_ff, stat_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    sent_valid_ff, sent_valid_in;
   logic [TAG_BITS-1:0]     sent_tag_ff, sent_tag_in;
   logic [WB-1:0]           sent_word_ff, sent_word_in;
   rrb_pkg::status_type     rsp_stat_ff, rsp_stat_in;
   logic [CNT_BITS-1:0]     occ_ff, occ_in;
   logic                    nearly_ff, nearly_in;
   logic                    start_ff, start_in;

   logic                    accept;
   logic                    rsp_free;
   logic                    full;
   logic                    send_op;
   logic                    sent;
   logic [CNT_BITS-1:0]     count_after;
   logic [TAG_BITS-1:0]     in_tag;
   rrb_pkg::cell_ctrl_type  ctrl;

   // chains through the cell row
   logic [DEPTH:0]          hit_chain;
   logic [DEPTH:0]          done_chain;
   logic [TAG_BITS-1:0]     sel_tag_chain  [DEPTH+1];
   logic [WB-1:0]           sel_word_chain [DEPTH+1];
   logic [DEPTH-1:0]        cell_valid;
   logic [DEPTH-1:0]        cell_done;
   logic [TAG_BITS-1:0]     cell_tag  [DEPTH];
   logic [WB-1:0]           cell_word [DEPTH];

   // fit the port tag to the stored tag width
   if (TAG_BITS <= TP) begin : g_tag_narrow
      assign in_tag              = req_bus.req_tag[TAG_BITS-1:0];
      assign rsp_bus.sent_tag    = TP'(sent_tag_ff);
   end else begin : g_tag_wide
      assign in_tag              = {{(TAG_BITS - TP){1'b0}}, req_bus.req_tag};
      assign rsp_bus.sent_tag    = sent_tag_ff[TP-1:0];
   end

   // occupancy field is the count, cut to its low bits or zero-extended
   if (CNT_BITS >= OB) begin : g_occ_trunc
      assign rsp_bus.occupancy = occ_ff[OB-1:0];
   end else begin : g_occ_ext
      assign rsp_bus.occupancy = {{(OB - CNT_BITS){1'b0}}, occ_ff};
   end

   // handshake
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;
   assign rsp_free      = ~rsp_valid_ff | rsp_bus.ready;
   assign full          = (count_ff == FULL_CNT);
   assign send_op       = (op_ff == rrb_pkg::OP_REPLY) || (op_ff == rrb_pkg::OP_SEND);

   // commands to the cells
   always_comb begin
      ctrl.push = accept && (req_bus.op == rrb_pkg::OP_PUSH);
      ctrl.mark = accept && (req_bus.op == rrb_pkg::OP_REPLY);
      ctrl.send = (state_ff == S_SEND) && rsp_free && send_op && free_ff;
   end

   // cell row
   assign hit_chain[0]      = 1'b0;
   assign done_chain[0]     = 1'b0;
   assign sel_tag_chain[0]  = '0;
   assign sel_word_chain[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic              left_v;
      logic              nxt_v;
      logic              nxt_d;
      logic [TAG_BITS-1:0] nxt_t;
      logic [WB-1:0]     nxt_w;

      if (i == 0) begin : g_first
         assign left_v = 1'b1;
      end else begin : g_mid
         assign left_v = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign nxt_v = 1'b0;
         assign nxt_d = 1'b0;
         assign nxt_t = '0;
         assign nxt_w = '0;
      end else begin : g_inner
         assign nxt_v = cell_valid[i+1];
         assign nxt_d = cell_done[i+1];
         assign nxt_t = cell_tag[i+1];
         assign nxt_w = cell_word[i+1];
      end

      rrb_cell #(
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .cmp_tag      (in_tag),
         .new_word     (req_bus.req_word),
         .left_valid   (left_v),
         .hit_in       (hit_chain[i]),
         .hit_out      (hit_chain[i+1]),
         .done_in      (done_chain[i]),
         .done_out     (done_chain[i+1]),
         .sel_tag_in   (sel_tag_chain[i]),
         .sel_tag_out  (sel_tag_chain[i+1]),
         .sel_word_in  (sel_word_chain[i]),
         .sel_word_out (sel_word_chain[i+1]),
         .next_valid   (nxt_v),
         .next_done    (nxt_d),
         .next_tag     (nxt_t),
         .next_word    (nxt_w),
         .valid        (cell_valid[i]),
         .done         (cell_done[i]),
         .tag          (cell_tag[i]),
         .word         (cell_word[i])
      );
   end

   assign sent        = ctrl.send & done_chain[DEPTH];
   assign count_after = count_ff - CNT_BITS'(sent);

   // sequencer, count and latched request info
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      op_in    = op_ff;
      free_in  = free_ff;
      stat_in  = stat_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SEND;
               op_in    = req_bus.op;
               free_in  = req_bus.downstream_free;
               stat_in  = rrb_pkg::STAT_OK;
               if (req_bus.op == rrb_pkg::OP_PUSH) begin
                  if (full) begin
                     stat_in = rrb_pkg::STAT_DROPPED;
                  end else begin
                     count_in = count_ff + CNT_BITS'(1);
                  end
               end else if (req_bus.op == rrb_pkg::OP_REPLY && !hit_chain[DEPTH]) begin
                  stat_in = rrb_pkg::STAT_NOT_FOUND;
               end
            end
         end
         S_SEND: begin
            if (rsp_free) begin
               state_in = S_IDLE;
               count_in = count_after;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      sent_valid_in = sent_valid_ff;
      sent_tag_in   = sent_tag_ff;
      sent_word_in  = sent_word_ff;
      rsp_stat_in   = rsp_stat_ff;
      occ_in        = occ_ff;
      nearly_in     = nearly_ff;
      start_in      = start_ff;
      if (state_ff == S_SEND && rsp_free) begin
         rsp_valid_in  = 1'b1;
         sent_valid_in = sent;
         sent_tag_in   = sent ? sel_tag_chain[DEPTH]  : '0;
         sent_word_in  = sent ? sel_word_chain[DEPTH] : '0;
         rsp_stat_in   = stat_ff;
         occ_in        = count_after;
         nearly_in     = count_after > NEAR_LIM;
         start_in      = {count_after, 2'b00} <= START_LIM;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      free_ff       <= free_in;
      stat_ff       <= stat_in;
      sent_valid_ff <= sent_valid_in;
      sent_tag_ff   <= sent_tag_in;
      sent_word_ff  <= sent_word_in;
      rsp_stat_ff   <= rsp_stat_in;
      occ_ff        <= occ_in;
      nearly_ff     <= nearly_in;
      start_ff      <= start_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.sent_valid  = sent_valid_ff;
   assign rsp_bus.sent_word   = sent_word_ff;
   assign rsp_bus.status      = rsp_stat_ff;
   assign rsp_bus.nearly_full = nearly_ff;
   assign rsp_bus.can_start   = start_ff;

endmodule

FILE: rtl/rrb_checker.sv
// rrb_checker: port-level assertions for response_reorder_buffer_core
// attached to the top level by the bind at the end; depends on rrb_pkg
module rrb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_sent_valid,
   input logic [rrb_pkg::TAG_PORT_BITS-1:0] rsp_sent_tag,
   input logic [rrb_pkg::WORD_BITS-1:0]     rsp_sent_word,
   input rrb_pkg::status_type               rsp_status
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its word
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sent_tag) && $stable(rsp_sent_word)
                                  && $stable(rsp_status))
      else $error("response word changed while stalled");

   // one request at a time: busy in the cycle after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   // a dropped push never emits an entry
   a_drop_no_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rrb_pkg::STAT_DROPPED |-> !rsp_sent_valid)
      else $error("dropped push reported an emitted entry");

   // nothing emitted means zero tag and word
   a_idle_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sent_valid |-> rsp_sent_tag == '0 && rsp_sent_word == '0)
      else $error("payload nonzero without an emitted entry");

endmodule

bind response_reorder_buffer_core rrb_checker u_rrb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_sent_valid (rsp_bus.sent_valid),
   .rsp_sent_tag   (rsp_bus.sent_tag),
   .rsp_sent_word  (rsp_bus.sent_word),
   .rsp_status     (rsp_bus.status)
);
